// ===== rtl/dpr_pkg.sv =====
// dpr_pkg: shared types and constants of the damped rank iteration core.
// No dependencies.
`default_nettype none
package dpr_pkg;
  localparam int MaxNodes = 64;
  localparam int FracBits = 24;
  localparam int IdxW     = 6;
  localparam logic [24:0] RankMax = 25'h1FFFFFF;
  localparam logic [24:0] OneQ    = 25'd1 << FracBits;

  localparam logic [1:0] CfgNodes = 2'd0;
  localparam logic [1:0] CfgTol   = 2'd1;
  localparam logic [1:0] CfgDamp  = 2'd2;
  localparam logic [1:0] CfgLimit = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE, ST_INIT, ST_CHECK, ST_SUM, ST_TELE, ST_TNUM, ST_DIV, ST_ROW, ST_MAC,
    ST_LINK, ST_UPD, ST_EMIT
  } state_t;

  typedef struct packed {
    logic clr;
    logic load;
  } mac_ctl_t;
endpackage
`default_nettype wire

// ===== rtl/dpr_mac.sv =====
// dpr_mac: shared multiply unit with a 40-bit accumulator, product truncated.
// Clear together with load takes the product alone. Depends on dpr_pkg.
`default_nettype none
module dpr_mac import dpr_pkg::*; (
  input  wire logic        clk,
  input  wire mac_ctl_t    ctl,
  input  wire logic [24:0] op_a,
  input  wire logic [32:0] op_b,
  output logic      [39:0] acc
);
  logic [39:0] acc_r, acc_nxt;
  logic [57:0] prod;
  logic [39:0] prod_t;
  assign prod   = {33'd0, op_a} * {25'd0, op_b};
  assign prod_t = {6'd0, prod[57:24]};
  always_comb begin
    acc_nxt = acc_r;
    if (ctl.clr) acc_nxt = ctl.load ? prod_t : 40'd0;
    else if (ctl.load) acc_nxt = acc_r + prod_t;
  end
  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end
  assign acc = acc_r;
endmodule
`default_nettype wire

// ===== rtl/damped_pagerank_power_iteration_core.sv =====
// damped_pagerank_power_iteration_core: sequencer, stores and output stage.
// Depends on dpr_pkg and dpr_mac.
//
// channel  dir  handshake      payload
// in_      in   valid/stall    operation row col weight
// out_     out  valid/stall    node rank last converged iterations
// cfg_     in   valid/ready    index data
//
// A start runs the 1/N divide and then loads the start vector; each iteration then runs
// a sum pass, a teleport multiply, a 25-step divide and N rows through the single
// multiplier, and one more check precedes the results. in_stall stays high for the
// whole run.
// Results leave one per cycle, held while out_stall is high.
// Synchronous active-low reset restores the register defaults; the matrix
// memory is not cleared.
`default_nettype none
module damped_pagerank_power_iteration_core import dpr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_operation,
  input  wire logic [5:0]  in_row,
  input  wire logic [5:0]  in_col,
  input  wire logic [24:0] in_weight,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [5:0]       out_node,
  output logic [24:0]      out_rank,
  output logic             out_last,
  output logic             out_converged,
  output logic [15:0]      out_iterations,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [24:0] cfg_data
);
  logic [24:0] mem [MaxNodes*MaxNodes];
  logic [24:0] rnow_r [MaxNodes];
  logic [24:0] rbef_r [MaxNodes];
  state_t state_r, state_nxt;
  logic [6:0]  ncfg_r;
  logic [24:0] tol_r, damp_r;
  logic [15:0] lim_r, iter_r;
  logic [6:0]  n_r;
  logic [24:0] p_r;
  logic [IdxW-1:0] i_r, j_r;
  logic [32:0] chg_r;
  logic [31:0] sumv_r;
  logic [39:0] num_r;
  logic [24:0] quo_r, tele_r;
  logic [4:0]  dcnt_r;
  logic        dfor_tele_r;
  logic [24:0] mrd_r;
  logic        mrd_v_r;
  logic        iss_r;
  logic [24:0] rnr_r, rbd_r, rbi_r;
  logic        conv_r;
  logic [39:0] acc;
  mac_ctl_t    mctl;
  logic [24:0] ma;
  logic [32:0] mb;
  logic        acc_in;
  logic        fin;
  logic [IdxW-1:0] nm1;
  logic [IdxW-1:0] ra;
  logic [40:0] val;
  logic [24:0] vs, dv;

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign acc_in    = in_valid && !in_stall;
  assign nm1       = IdxW'(n_r - 7'd1);
  assign fin       = (chg_r <= {8'd0, tol_r}) || (iter_r >= lim_r);

  always_ff @(posedge clk) begin
    if (acc_in && !in_operation) mem[{in_row, in_col}] <= in_weight;
    mrd_r <= mem[{j_r, i_r}];
  end

  // rank stores: registered reads; the rnow_r address is issued in the cycle before its data is used
  always_comb begin
    ra = i_r;
    if (state_r == ST_CHECK) ra = '0;
    else if (state_r == ST_SUM || (state_r == ST_EMIT && !out_stall)) ra = i_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    rnr_r <= rnow_r[ra];
    rbd_r <= rbef_r[j_r];
    rbi_r <= rbef_r[i_r];
  end

  always_comb begin
    mctl = '0;
    ma = mrd_r;
    mb = {8'd0, rbd_r};
    if (state_r == ST_ROW) mctl.clr = 1'b1;
    if (state_r == ST_MAC && mrd_v_r) mctl.load = 1'b1;
    if (state_r == ST_TELE) begin
      mctl.clr = 1'b1;
      mctl.load = 1'b1;
      ma = p_r;
      mb = {1'b0, sumv_r};
    end
    if (state_r == ST_LINK) begin
      mctl.clr = 1'b1;
      mctl.load = 1'b1;
      ma = OneQ - p_r;
      mb = acc[32:0];
    end
  end
  dpr_mac u_mac (.clk(clk), .ctl(mctl), .op_a(ma), .op_b(mb), .acc(acc));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (acc_in && in_operation) state_nxt = ST_DIV;
      ST_INIT:  if (i_r == nm1) state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = fin ? ST_EMIT : ST_SUM;
      ST_SUM:   if (i_r == nm1) state_nxt = ST_TELE;
      ST_TELE:  state_nxt = ST_TNUM;
      ST_TNUM:  state_nxt = ST_DIV;
      ST_DIV:   if (dcnt_r == 5'd0) state_nxt = dfor_tele_r ? ST_ROW : ST_INIT;
      ST_ROW:   state_nxt = ST_MAC;
      ST_MAC:   if (mrd_v_r && !iss_r) state_nxt = ST_LINK;
      ST_LINK:  state_nxt = ST_UPD;
      ST_UPD:   state_nxt = (i_r == nm1) ? ST_CHECK : ST_ROW;
      ST_EMIT:  if (!out_stall && i_r == nm1) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  assign val = {1'b0, acc} + {16'd0, tele_r};
  assign vs  = (|val[40:25]) ? RankMax : val[24:0];
  assign dv  = (vs >= rbi_r) ? vs - rbi_r : rbi_r - vs;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ncfg_r <= 7'd4; tol_r <= 25'd17; damp_r <= 25'd2516582; lim_r <= 16'hFFFF;
      iter_r <= '0; i_r <= '0; j_r <= '0; mrd_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          CfgNodes: ncfg_r <= cfg_data[6:0];
          CfgTol:   tol_r  <= cfg_data;
          CfgDamp:  damp_r <= cfg_data;
          CfgLimit: lim_r  <= cfg_data[15:0];
          default:  ;
        endcase
      end
      unique case (state_r)
        ST_IDLE: if (acc_in && in_operation) begin
          n_r <= (ncfg_r == 7'd0) ? 7'd1 : (ncfg_r > 7'd64) ? 7'd64 : ncfg_r;
          p_r <= (damp_r > OneQ) ? OneQ : damp_r;
          num_r <= {15'd0, OneQ}; quo_r <= '0; dcnt_r <= 5'd24;
          dfor_tele_r <= 1'b0; iter_r <= '0; i_r <= '0;
          chg_r <= {8'd0, OneQ};
        end
        ST_INIT: begin
          rnow_r[i_r] <= quo_r;
          i_r <= i_r + 1'b1;
        end
        ST_CHECK: begin
          i_r <= '0; sumv_r <= '0;
          conv_r <= (chg_r <= {8'd0, tol_r});
        end
        ST_SUM: begin
          rbef_r[i_r] <= rnr_r;
          sumv_r <= sumv_r + {7'd0, rnr_r};
          i_r <= i_r + 1'b1;
        end
        ST_TELE: ;
        ST_TNUM: begin
          num_r <= acc;
          quo_r <= '0; dcnt_r <= 5'd24; dfor_tele_r <= 1'b1;
          chg_r <= '0;
        end
        ST_DIV: begin
          if (num_r >= ({33'd0, n_r} << dcnt_r)) begin
            num_r <= num_r - ({33'd0, n_r} << dcnt_r);
            quo_r[dcnt_r] <= 1'b1;
          end
          dcnt_r <= dcnt_r - 5'd1;
          i_r <= '0;
        end
        ST_ROW: begin
          if (dfor_tele_r) tele_r <= quo_r;
          dfor_tele_r <= 1'b0;
          j_r <= '0; iss_r <= 1'b1; mrd_v_r <= 1'b0;
        end
        ST_MAC: begin
          mrd_v_r <= iss_r;
          if (iss_r) begin
            j_r <= j_r + 1'b1;
            if (j_r == nm1) iss_r <= 1'b0;
          end
        end
        ST_LINK: ;
        ST_UPD: begin
          rnow_r[i_r] <= vs;
          chg_r <= chg_r + {8'd0, dv};
          i_r <= i_r + 1'b1;
          if (i_r == nm1) iter_r <= iter_r + 16'd1;
        end
        ST_EMIT: if (!out_stall) i_r <= i_r + 1'b1;
        default: ;
      endcase
    end
  end

  assign out_valid      = (state_r == ST_EMIT);
  assign out_node       = i_r;
  assign out_rank       = rnr_r;
  assign out_last       = (i_r == nm1);
  assign out_converged  = conv_r;
  assign out_iterations = iter_r;
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// tb_top: self-checking bench for damped_pagerank_power_iteration_core.
// Depends on dpr_pkg. Matrix loads and rank runs are predicted in-bench and
// every emitted rank is compared in order; random idling on both channels.
`default_nettype none
module tb_top import dpr_pkg::*; ();

  typedef struct {
    logic [5:0]  node;
    logic [24:0] rank;
    logic        last;
    logic        converged;
    logic [15:0] iterations;
  } rank_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_operation = 1'b0;
  logic [5:0]  in_row = '0;
  logic [5:0]  in_col = '0;
  logic [24:0] in_weight = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [5:0]  out_node;
  logic [24:0] out_rank;
  logic        out_last;
  logic        out_converged;
  logic [15:0] out_iterations;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [24:0] cfg_data = '0;

  damped_pagerank_power_iteration_core DUT (.*);

  always #4 clk = ~clk;

  // predictor state
  logic [24:0] mat [0:4095];
  bit          written [0:4095];
  logic [24:0] rank_vec [0:63];
  logic [6:0]  nodes_reg = 7'd4;
  logic [24:0] tol_reg = 25'd17;
  logic [24:0] damp_reg = 25'd2516582;
  logic [15:0] limit_reg = 16'd65535;

  rank_res_t rank_expect_q [$];
  int errors = 0;
  int ranks_seen = 0;
  int runs_done = 0;
  int items_sent = 0;
  bit idle_on = 1'b1;
  bit hold_arm = 1'b0;
  int hold_cnt = 0;
  int burst = 0;

  function automatic int eff_nodes();
    int n;
    n = nodes_reg;
    if (n < 1) n = 1;
    if (n > MaxNodes) n = MaxNodes;
    return n;
  endfunction

  function automatic void predict_ranks();
    int n, iters;
    longint unsigned p, q, sumv, acc, val, diff, chg, init;
    logic [24:0] prev [0:63];
    rank_res_t r;
    n = eff_nodes();
    p = (damp_reg > OneQ) ? OneQ : damp_reg;
    q = OneQ - p;
    init = OneQ / n;
    for (int i = 0; i < n; i++) rank_vec[i] = init[24:0];
    iters = 0;
    chg = OneQ;
    while (chg > tol_reg && iters < limit_reg) begin
      sumv = 0;
      diff = 0;
      for (int i = 0; i < n; i++) begin
        prev[i] = rank_vec[i];
        sumv += prev[i];
      end
      for (int i = 0; i < n; i++) begin
        acc = 0;
        for (int j = 0; j < n; j++)
          acc += (longint'(mat[j*MaxNodes+i]) * prev[j]) >> FracBits;
        val = ((q * acc) >> FracBits) + ((p * sumv) >> FracBits) / n;
        if (val > RankMax) val = RankMax;
        rank_vec[i] = val[24:0];
        diff += (val >= prev[i]) ? val - prev[i] : prev[i] - val;
      end
      chg = (diff > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : diff;
      iters = (iters + 1) & 16'hFFFF;
    end
    for (int i = 0; i < n; i++) begin
      r.node = i[5:0];
      r.rank = rank_vec[i];
      r.last = (i == n - 1);
      r.converged = (chg <= tol_reg);
      r.iterations = iters[15:0];
      rank_expect_q.push_back(r);
    end
  endfunction

  task automatic send_item(input logic op, input logic [5:0] row, input logic [5:0] col,
                           input logic [24:0] w);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_operation <= op;
    in_row <= row;
    in_col <= col;
    in_weight <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (op == 1'b0) begin
      mat[row*MaxNodes+col] = w;
      written[row*MaxNodes+col] = 1'b1;
    end else begin
      predict_ranks();
      runs_done++;
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (rank_expect_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [24:0] d);
    in_valid <= 1'b0;
    cfg_index <= idx;
    cfg_data <= d;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CfgNodes: nodes_reg = d[6:0];
      CfgTol:   tol_reg = d;
      CfgDamp:  damp_reg = d;
      CfgLimit: limit_reg = d[15:0];
      default: ;
    endcase
  endtask

  function automatic logic [24:0] rand_weight();
    if ($urandom_range(0, 9) == 0) return 25'($urandom());
    return 25'($urandom_range(0, OneQ));
  endfunction

  // load every entry of the active n x n block that is still unwritten, or every entry when uniform
  task automatic fill_matrix(input bit uniform);
    int n;
    n = eff_nodes();
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++)
        if (uniform || !written[r*MaxNodes+c])
          send_item(1'b0, r[5:0], c[5:0], uniform ? 25'(OneQ / n) : rand_weight());
  endtask

  task automatic start_run();
    send_item(1'b1, 6'($urandom()), 6'($urandom()), 25'($urandom()));
  endtask

  task automatic set_all(input logic [6:0] n, input logic [24:0] t, input logic [24:0] p,
                         input logic [15:0] l);
    cfg_write(CfgNodes, 25'(n));
    cfg_write(CfgTol, t);
    cfg_write(CfgDamp, p);
    cfg_write(CfgLimit, 25'(l));
  endtask

  task automatic test_defaults();
    fill_matrix(1'b1);
    start_run();
    drain();
  endtask

  task automatic test_extremes();
    set_all(7'd0, 25'd0, 25'd0, 16'd1);
    fill_matrix(1'b0);
    start_run();
    drain();
    set_all(7'd3, OneQ, 25'h1FFFFFF, 16'd65535);
    fill_matrix(1'b0);
    start_run();
    drain();
    cfg_write(CfgTol, 25'h1FFFFFF);
    cfg_write(CfgLimit, 25'd0);
    start_run();
    drain();
    cfg_write(CfgTol, 25'd0);
    start_run();
    drain();
    send_item(1'b0, 6'd63, 6'd63, 25'h1FFFFFF);
    send_item(1'b0, 6'd0, 6'd63, 25'd0);
    set_all(7'd5, 25'd0, OneQ, 16'd2);
    fill_matrix(1'b0);
    start_run();
    drain();
    set_all(7'd2, 25'd0, 25'd0, 16'd3);
    send_item(1'b0, 6'd0, 6'd0, 25'h1FFFFFF);
    send_item(1'b0, 6'd1, 6'd0, 25'h1FFFFFF);
    start_run();
    drain();
  endtask

  task automatic random_phase();
    set_all(7'($urandom_range(1, 8)), 25'($urandom_range(0, 3000)),
            ($urandom_range(0, 5) == 0) ? 25'($urandom()) : 25'($urandom_range(0, OneQ)),
            16'($urandom_range(1, 30)));
    repeat ($urandom_range(0, 4))
      send_item(1'b0, 6'($urandom()), 6'($urandom()), rand_weight());
    fill_matrix(1'b0);
    start_run();
    if ($urandom_range(0, 1)) start_run();
    drain();
  endtask

  task automatic test_random_runs();
    repeat (14) random_phase();
  endtask

  task automatic test_backpressure();
    set_all(7'd6, 25'd0, 25'd2516582, 16'd5);
    fill_matrix(1'b0);
    hold_arm = 1'b1;
    start_run();
    repeat (6) send_item(1'b0, 6'($urandom_range(0, 5)), 6'($urandom_range(0, 5)),
                         rand_weight());
    start_run();
    drain();
  endtask

  task automatic test_steady_stream();
    idle_on = 1'b0;
    repeat (4) random_phase();
  endtask

  always @(posedge clk) begin
    if (hold_arm && hold_cnt < 2000) begin
      out_stall <= 1'b1;
      hold_cnt <= hold_cnt + 1;
    end else if (burst > 0) begin
      out_stall <= 1'b1;
      burst <= burst - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      burst <= $urandom_range(0, 8);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      ranks_seen++;
      if (rank_expect_q.size() == 0) begin
        $error("unexpected rank for node %0d", out_node);
        errors++;
      end else begin
        rank_res_t e;
        e = rank_expect_q.pop_front();
        if (out_node !== e.node) begin
          $error("node: expected %0d, got %0d", e.node, out_node); errors++;
        end
        if (out_rank !== e.rank) begin
          $error("rank: expected %0d, got %0d", e.rank, out_rank); errors++;
        end
        if (out_last !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, out_last); errors++;
        end
        if (out_converged !== e.converged) begin
          $error("converged: expected %0d, got %0d", e.converged, out_converged); errors++;
        end
        if (out_iterations !== e.iterations) begin
          $error("iterations: expected %0d, got %0d", e.iterations, out_iterations);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_defaults();
    test_extremes();
    test_random_runs();
    test_backpressure();
    test_steady_stream();
    if (rank_expect_q.size() != 0) begin
      $error("%0d ranks never arrived", rank_expect_q.size());
      errors++;
    end
    $display("%0d items sent, %0d ranking runs, %0d ranks checked", items_sent, runs_done,
             ranks_seen);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("TEST FAILED");
    $finish;
  end
endmodule
`default_nettype wire
